### rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the LED pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   localparam int LED_COUNT_DEF = 5;
   localparam int LED_MAX       = 16;

   localparam int NOW_W    = 32;
   localparam int ADC_W    = 12;
   localparam int LEDS_W   = 5;
   localparam int TEMP_W   = 5;
   localparam int PERIOD_W = 16;
   localparam int SEED_W   = 16;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;
   localparam logic [SEED_W-1:0]   SEED_RESET   = 16'd44257;
   localparam logic [SEED_W-1:0]   LFSR_TAPS    = 16'hB400;

   // temperature scaling: floor(adc * 330 / 4095) - 50, clamped to 0..31
   localparam int TEMP_SCALE  = 330;
   localparam int ADC_FULL    = 4095;
   localparam int TEMP_OFFSET = 50;
   localparam int TEMP_MAX    = 31;

   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_BLINK   = 3'd1,
      MODE_CHASE   = 3'd2,
      MODE_WAVE    = 3'd3,
      MODE_FLICKER = 3'd4,
      MODE_TEMP    = 3'd5,
      MODE_MANUAL  = 3'd6
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_PERIOD = 2'd1,
      CSR_MANUAL = 2'd2,
      CSR_SEED   = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [NOW_W-1:0] now_ms;
      logic [ADC_W-1:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic [LEDS_W-1:0] leds;
      logic [TEMP_W-1:0] temp_clamped;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/lpg_temp.sv
// ----------------------------------------------------------------------------
// lpg_temp
// Converts a 12-bit sensor sample to whole degrees, clamped to 0..31.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_temp (
   input  wire logic [lpg_pkg::ADC_W-1:0]  adc_sample,
   output logic      [lpg_pkg::TEMP_W-1:0] temp_clamped
);

   localparam int PROD_W = 21;
   localparam int QUOT_W = 9;
   localparam int REM_W  = 13;

   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] q_est;
   logic [REM_W-1:0]  rem_est;
   logic [QUOT_W-1:0] quot;

   // divide by 4095 as divide by 4096 plus one correction step
   always_comb begin
      prod    = PROD_W'(adc_sample) * PROD_W'(lpg_pkg::TEMP_SCALE);
      q_est   = prod[PROD_W-1:12];
      rem_est = REM_W'(prod[11:0]) + REM_W'(q_est);
      quot    = q_est + QUOT_W'(rem_est >= REM_W'(lpg_pkg::ADC_FULL));
      if (quot < QUOT_W'(lpg_pkg::TEMP_OFFSET)) begin
         temp_clamped = '0;
      end else if (quot > QUOT_W'(lpg_pkg::TEMP_OFFSET + lpg_pkg::TEMP_MAX)) begin
         temp_clamped = lpg_pkg::TEMP_W'(lpg_pkg::TEMP_MAX);
      end else begin
         temp_clamped = lpg_pkg::TEMP_W'(quot - QUOT_W'(lpg_pkg::TEMP_OFFSET));
      end
   end

endmodule

`default_nettype wire

### rtl/led_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_pattern_generator
// Drives a row of LEDs in off, blink, chase, wave, flicker, temperature or
// manual mode, one update per time/temperature beat.
// ----------------------------------------------------------------------------
// Each request beat is captured in an input register; when the response
// register is free or drained, the animation step, temperature conversion and
// LED update are done in one pass into the response register, and one beat is
// taken every cycle while the response side keeps draining. Timed modes step
// when now_ms minus the last step time (mod 2^32) reaches the period (half the
// period in flicker mode). Writing the mode register restarts the animation.
// CSR writes are meant for idle periods only.
`default_nettype none

module led_pattern_generator #(
   parameter int LED_COUNT = lpg_pkg::LED_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire lpg_pkg::req_type                req_data,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output lpg_pkg::rsp_type                     rsp_data,

   input  wire logic                            csr_wr_en,
   input  wire logic [lpg_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [lpg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CHASE_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int WAVE_W  = $clog2(2 * LED_COUNT);
   localparam int NOW_W   = lpg_pkg::NOW_W;
   localparam int SEED_W  = lpg_pkg::SEED_W;

   // configuration
   lpg_pkg::mode_type                 mode_ff,   mode_in;
   logic [lpg_pkg::PERIOD_W-1:0]      period_ff, period_in;
   logic [lpg_pkg::LEDS_W-1:0]        manual_ff, manual_in;
   logic [SEED_W-1:0]                 seed_ff,   seed_in;

   // animation state
   logic [LED_COUNT-1:0]              led_ff,    led_in;
   logic [NOW_W-1:0]                  last_ff,   last_in;
   logic [CHASE_W-1:0]                chase_ff,  chase_in;
   logic [WAVE_W-1:0]                 wave_ff,   wave_in;
   logic                              blink_ff,  blink_in;
   logic [SEED_W-1:0]                 lfsr_ff,   lfsr_in;

   // pipeline
   logic                              s1_valid_ff, s1_valid_in;
   lpg_pkg::req_type                  s1_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   lpg_pkg::rsp_type                  rsp_data_ff,  rsp_data_in;

   logic                              advance;
   logic [lpg_pkg::TEMP_W-1:0]        temp;
   logic [NOW_W-1:0]                  elapsed;
   logic [lpg_pkg::PERIOD_W-1:0]      step_period;
   logic                              due;
   logic [WAVE_W-1:0]                 wave_n;
   logic [LED_COUNT-1:0]              wave_leds;
   logic [LED_COUNT-1:0]              flick_leds;
   logic [SEED_W-1:0]                 flick_lfsr;
   logic [lpg_pkg::LED_MAX-1:0]       temp_wide;
   logic [lpg_pkg::LED_MAX-1:0]       manual_wide;
   logic [lpg_pkg::LED_MAX-1:0]       led_wide;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   lpg_temp u_temp (
      .adc_sample   (s1_data_ff.adc_sample),
      .temp_clamped (temp)
   );

   assign temp_wide   = lpg_pkg::LED_MAX'(temp);
   assign manual_wide = lpg_pkg::LED_MAX'(manual_ff);

   always_comb begin
      elapsed     = s1_data_ff.now_ms - last_ff;
      step_period = (mode_ff == lpg_pkg::MODE_FLICKER) ? (period_ff >> 1) : period_ff;
      due         = elapsed >= NOW_W'(step_period);
   end

   always_comb begin
      wave_n = (wave_ff < WAVE_W'(LED_COUNT)) ? wave_ff
                                              : WAVE_W'(2 * LED_COUNT - 1) - wave_ff;
      for (int i = 0; i < LED_COUNT; i++) begin
         wave_leds[i] = wave_n > WAVE_W'(i);
      end
   end

   // one LFSR shift per LED, bit shifted out drives that LED
   always_comb begin
      flick_lfsr = lfsr_ff;
      for (int i = 0; i < LED_COUNT; i++) begin
         flick_leds[i] = flick_lfsr[0];
         flick_lfsr    = (flick_lfsr >> 1) ^ (flick_lfsr[0] ? lpg_pkg::LFSR_TAPS : '0);
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      period_in = period_ff;
      manual_in = manual_ff;
      seed_in   = seed_ff;
      led_in    = led_ff;
      last_in   = last_ff;
      chase_in  = chase_ff;
      wave_in   = wave_ff;
      blink_in  = blink_ff;
      lfsr_in   = lfsr_ff;

      if (advance) begin
         case (mode_ff)
            lpg_pkg::MODE_BLINK: begin
               if (due) begin
                  last_in  = s1_data_ff.now_ms;
                  blink_in = !blink_ff;
                  led_in   = {LED_COUNT{!blink_ff}};
               end
            end
            lpg_pkg::MODE_CHASE: begin
               if (due) begin
                  last_in  = s1_data_ff.now_ms;
                  led_in   = LED_COUNT'(1) << chase_ff;
                  chase_in = (chase_ff == CHASE_W'(LED_COUNT - 1)) ? '0 : chase_ff + 1'b1;
               end
            end
            lpg_pkg::MODE_WAVE: begin
               if (due) begin
                  last_in = s1_data_ff.now_ms;
                  led_in  = wave_leds;
                  wave_in = (wave_ff == WAVE_W'(2 * LED_COUNT - 1)) ? '0 : wave_ff + 1'b1;
               end
            end
            lpg_pkg::MODE_FLICKER: begin
               if (due) begin
                  last_in = s1_data_ff.now_ms;
                  led_in  = flick_leds;
                  lfsr_in = flick_lfsr;
               end
            end
            lpg_pkg::MODE_TEMP: begin
               led_in = temp_wide[LED_COUNT-1:0];
            end
            lpg_pkg::MODE_MANUAL: begin
               led_in = manual_wide[LED_COUNT-1:0];
            end
            default: begin
            end
         endcase
      end

      if (csr_wr_en) begin
         case (csr_addr)
            lpg_pkg::CSR_MODE: begin
               mode_in  = lpg_pkg::mode_type'(csr_wdata[2:0]);
               last_in  = '0;
               chase_in = '0;
               wave_in  = '0;
               blink_in = 1'b0;
               lfsr_in  = seed_ff;
               if (mode_in != lpg_pkg::MODE_MANUAL) begin
                  led_in = '0;
               end
            end
            lpg_pkg::CSR_PERIOD: period_in = csr_wdata[lpg_pkg::PERIOD_W-1:0];
            lpg_pkg::CSR_MANUAL: manual_in = csr_wdata[lpg_pkg::LEDS_W-1:0];
            lpg_pkg::CSR_SEED:   seed_in   = csr_wdata[SEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign led_wide = lpg_pkg::LED_MAX'(led_in);

   always_comb begin
      s1_valid_in  = advance ? 1'b0 : s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || advance;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in.leds         = led_wide[lpg_pkg::LEDS_W-1:0];
         rsp_data_in.temp_clamped = temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lpg_pkg::MODE_OFF;
         period_ff    <= lpg_pkg::PERIOD_RESET;
         manual_ff    <= '0;
         seed_ff      <= lpg_pkg::SEED_RESET;
         led_ff       <= '0;
         last_ff      <= '0;
         chase_ff     <= '0;
         wave_ff      <= '0;
         blink_ff     <= 1'b0;
         lfsr_ff      <= lpg_pkg::SEED_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         period_ff    <= period_in;
         manual_ff    <= manual_in;
         seed_ff      <= seed_in;
         led_ff       <= led_in;
         last_ff      <= last_in;
         chase_ff     <= chase_in;
         wave_ff      <= wave_in;
         blink_ff     <= blink_in;
         lfsr_ff      <= lfsr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
